// ===== rtl/core/ttb_pkg.sv =====
// Shared types, widths and helper functions for the triangle tangent/binormal block.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package ttb_pkg;

   // Input and output number formats
   localparam int COORD_BITS     = 16;
   localparam int UNIT_FRAC_BITS = 14;

   // Normalization head: largest magnitude is scaled to this many significant bits
   localparam int HEAD_BITS = 30;

   // Edge differences, pre-shifted when coordinates are very wide
   localparam int PRE_SHIFT = (COORD_BITS > HEAD_BITS) ? COORD_BITS - HEAD_BITS : 0;
   localparam int DIFF_BITS = (COORD_BITS < 31) ? COORD_BITS + 1 : 32;

   // Unit results and vector components
   localparam int OUT_BITS  = UNIT_FRAC_BITS + 2;
   localparam int VEC_A     = 2 * DIFF_BITS + 1;
   localparam int VEC_B     = 2 * OUT_BITS + 1;
   localparam int VEC_BITS  = (VEC_A > VEC_B) ? VEC_A : VEC_B;
   localparam int MAG_BITS  = (VEC_BITS > HEAD_BITS) ? VEC_BITS : HEAD_BITS;

   // Shared multiplier, square root and divider widths
   localparam int MUL_BITS  = 32;
   localparam int PROD_BITS = 2 * MUL_BITS;
   localparam int SUM_BITS  = 2 * HEAD_BITS + 2;
   localparam int LEN_BITS  = HEAD_BITS + 1;
   localparam int QUO_BITS  = UNIT_FRAC_BITS + 2;
   localparam int DIV_BITS  = LEN_BITS + QUO_BITS + 1;

   // Sequencer step counts
   localparam int PROD_COUNT  = 18;
   localparam int CROSS_COUNT = 6;
   localparam int CNT_BITS    = $clog2((QUO_BITS > PROD_COUNT + 1) ? QUO_BITS : PROD_COUNT + 1);

   // Triangle queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Largest legal magnitude of a unit component
   localparam int UNIT_ONE = 1 << UNIT_FRAC_BITS;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
      logic signed [COORD_BITS-1:0] tex_u;
      logic signed [COORD_BITS-1:0] tex_v;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] tangent_x;
      logic signed [OUT_BITS-1:0] tangent_y;
      logic signed [OUT_BITS-1:0] tangent_z;
      logic signed [OUT_BITS-1:0] binormal_x;
      logic signed [OUT_BITS-1:0] binormal_y;
      logic signed [OUT_BITS-1:0] binormal_z;
      logic                       degenerate;
   } rsp_type;

   // One triangle worth of edge differences
   typedef struct packed {
      logic signed [DIFF_BITS-1:0] s0_x;
      logic signed [DIFF_BITS-1:0] s0_y;
      logic signed [DIFF_BITS-1:0] s0_z;
      logic signed [DIFF_BITS-1:0] s1_x;
      logic signed [DIFF_BITS-1:0] s1_y;
      logic signed [DIFF_BITS-1:0] s1_z;
      logic signed [DIFF_BITS-1:0] du0;
      logic signed [DIFF_BITS-1:0] du1;
      logic signed [DIFF_BITS-1:0] dv0;
      logic signed [DIFF_BITS-1:0] dv1;
   } tri_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_THIRD
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PROD,
      S_LOAD,
      S_FIT,
      S_SQ,
      S_ROOT,
      S_DINIT,
      S_DIV,
      S_CROSS,
      S_DOT,
      S_OUT
   } back_state_type;

   typedef enum logic [1:0] {
      VS_NRM,
      VS_TAN,
      VS_BIN,
      VS_CRS
   } vec_sel_type;

   // Difference a - b, magnitude shifted toward zero for wide coordinates
   function automatic logic signed [DIFF_BITS-1:0] diff_f(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      logic signed [COORD_BITS:0] d;
      logic [COORD_BITS:0]        m;
      logic [COORD_BITS:0]        mn;
      d  = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      m  = d[COORD_BITS] ? $unsigned(-d) : $unsigned(d);
      m  = m >> PRE_SHIFT;
      mn = ~m + 1'b1;
      diff_f = d[COORD_BITS] ? DIFF_BITS'(mn) : DIFF_BITS'(m);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ttb_front.sv =====
// Vertex front end: groups three vertices into a triangle and forms its edge differences.
// Depends on ttb_pkg.
`default_nettype none

module ttb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ttb_pkg::req_type req_data,
   output logic             push_valid,
   input  logic             push_ready,
   output ttb_pkg::tri_type push_data
);
   import ttb_pkg::*;

   phase_type phase_ff, phase_in;
   req_type   v0_ff, v0_in;
   req_type   v1_ff, v1_in;
   logic      take;

   // Phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Stored vertices, no reset
   always_ff @(posedge clock) begin
      v0_ff <= v0_in;
      v1_ff <= v1_in;
   end

   // Third vertex goes straight to the queue; edge differences are formed here
   always_comb begin
      phase_in   = phase_ff;
      v0_in      = v0_ff;
      v1_in      = v1_ff;
      push_valid = req_valid && (phase_ff == PH_THIRD);
      req_ready  = (phase_ff != PH_THIRD) || push_ready;
      take       = req_valid && req_ready;

      push_data.s0_x = diff_f(v0_ff.pos_x, v1_ff.pos_x);
      push_data.s0_y = diff_f(v0_ff.pos_y, v1_ff.pos_y);
      push_data.s0_z = diff_f(v0_ff.pos_z, v1_ff.pos_z);
      push_data.s1_x = diff_f(req_data.pos_x, v0_ff.pos_x);
      push_data.s1_y = diff_f(req_data.pos_y, v0_ff.pos_y);
      push_data.s1_z = diff_f(req_data.pos_z, v0_ff.pos_z);
      push_data.du0  = diff_f(v0_ff.tex_u, v1_ff.tex_u);
      push_data.du1  = diff_f(req_data.tex_u, v0_ff.tex_u);
      push_data.dv0  = diff_f(v0_ff.tex_v, v1_ff.tex_v);
      push_data.dv1  = diff_f(req_data.tex_v, v0_ff.tex_v);

      if (take) begin
         unique case (phase_ff)
            PH_SECOND: begin
               v1_in    = req_data;
               phase_in = PH_THIRD;
            end
            PH_THIRD: begin
               phase_in = PH_FIRST;
            end
            default: begin
               v0_in    = req_data;
               phase_in = PH_SECOND;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ttb_queue.sv =====
// Short triangle queue that decouples the vertex front end from the back end.
// Depends on ttb_pkg.
`default_nettype none

module ttb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ttb_pkg::tri_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output ttb_pkg::tri_type pop_data
);
   import ttb_pkg::*;

   tri_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ff, wr_in;
   logic [QPTR_BITS-1:0]  rd_ff, rd_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and fill count
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Store the pushed triangle
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ttb_back.sv =====
// Back end sequencer: products, normalization, square root, division, orientation test.
// One shared 32x32 multiplier; depends on ttb_pkg.
`default_nettype none

module ttb_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  ttb_pkg::tri_type pop_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ttb_pkg::rsp_type rsp_data
);
   import ttb_pkg::*;

   back_state_type state_ff, state_in;
   vec_sel_type    vsel_ff, vsel_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [1:0]          idx_ff, idx_in;

   tri_type tri_ff, tri_in;

   logic signed [VEC_BITS-1:0] nrm_ff [3], nrm_in [3];
   logic signed [VEC_BITS-1:0] tg_ff  [3], tg_in  [3];
   logic signed [VEC_BITS-1:0] bn_ff  [3], bn_in  [3];
   logic signed [VEC_BITS-1:0] cr_ff  [3], cr_in  [3];

   logic [MAG_BITS-1:0]  mag_ff [3], mag_in [3];
   logic [2:0]           neg_ff, neg_in;
   logic [HEAD_BITS-1:0] nm_ff [3], nm_in [3];
   logic [2:0]           nn_ff, nn_in;

   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [PROD_BITS-1:0] acc_ff, acc_in;

   logic [SUM_BITS-1:0] rx_ff, rx_in;
   logic [SUM_BITS-1:0] r_ff, r_in;
   logic [SUM_BITS-1:0] rbit_ff, rbit_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic [DIV_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0] dsh_ff, dsh_in;
   logic [QUO_BITS-1:0] q_ff, q_in;

   logic signed [OUT_BITS-1:0] tu_ff [3], tu_in [3];
   logic signed [OUT_BITS-1:0] bu_ff [3], bu_in [3];
   logic    deg_ff, deg_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Working signals of the sequencer
   logic signed [MUL_BITS-1:0]  mul_a, mul_b;
   logic signed [VEC_BITS-1:0]  src [3];
   logic [VEC_BITS-1:0]         absv;
   logic [MAG_BITS-1:0]         orv;
   logic [CNT_BITS-1:0]         prev;
   logic signed [VEC_BITS-1:0]  pair;
   logic signed [PROD_BITS-1:0] term;
   logic signed [PROD_BITS-1:0] dotv;
   logic [SUM_BITS-1:0]         root_t;
   logic [SUM_BITS-1:0]         root_r;
   logic                        ge;
   logic [QUO_BITS-1:0]         qn;
   logic signed [OUT_BITS-1:0]  uval;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   function automatic logic signed [MUL_BITS-1:0] head_op(input logic [HEAD_BITS-1:0] m);
      head_op = MUL_BITS'({1'b0, m});
   endfunction

   // Shared multiplier, registered product
   assign prod_in = mul_a * mul_b;

   // Select multiplier operands for the current step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_PROD: begin
            case (cnt_ff)
               0:  begin mul_a = MUL_BITS'(tri_ff.s1_y); mul_b = MUL_BITS'(tri_ff.s0_z); end
               1:  begin mul_a = MUL_BITS'(tri_ff.s1_z); mul_b = MUL_BITS'(tri_ff.s0_y); end
               2:  begin mul_a = MUL_BITS'(tri_ff.s1_z); mul_b = MUL_BITS'(tri_ff.s0_x); end
               3:  begin mul_a = MUL_BITS'(tri_ff.s1_x); mul_b = MUL_BITS'(tri_ff.s0_z); end
               4:  begin mul_a = MUL_BITS'(tri_ff.s1_x); mul_b = MUL_BITS'(tri_ff.s0_y); end
               5:  begin mul_a = MUL_BITS'(tri_ff.s1_y); mul_b = MUL_BITS'(tri_ff.s0_x); end
               6:  begin mul_a = MUL_BITS'(tri_ff.s0_x); mul_b = MUL_BITS'(tri_ff.dv1); end
               7:  begin mul_a = MUL_BITS'(tri_ff.s1_x); mul_b = MUL_BITS'(tri_ff.dv0); end
               8:  begin mul_a = MUL_BITS'(tri_ff.s0_y); mul_b = MUL_BITS'(tri_ff.dv1); end
               9:  begin mul_a = MUL_BITS'(tri_ff.s1_y); mul_b = MUL_BITS'(tri_ff.dv0); end
               10: begin mul_a = MUL_BITS'(tri_ff.s0_z); mul_b = MUL_BITS'(tri_ff.dv1); end
               11: begin mul_a = MUL_BITS'(tri_ff.s1_z); mul_b = MUL_BITS'(tri_ff.dv0); end
               12: begin mul_a = MUL_BITS'(tri_ff.s0_x); mul_b = MUL_BITS'(tri_ff.du1); end
               13: begin mul_a = MUL_BITS'(tri_ff.s1_x); mul_b = MUL_BITS'(tri_ff.du0); end
               14: begin mul_a = MUL_BITS'(tri_ff.s0_y); mul_b = MUL_BITS'(tri_ff.du1); end
               15: begin mul_a = MUL_BITS'(tri_ff.s1_y); mul_b = MUL_BITS'(tri_ff.du0); end
               16: begin mul_a = MUL_BITS'(tri_ff.s0_z); mul_b = MUL_BITS'(tri_ff.du1); end
               17: begin mul_a = MUL_BITS'(tri_ff.s1_z); mul_b = MUL_BITS'(tri_ff.du0); end
               default: ;
            endcase
         end
         S_SQ: begin
            if (cnt_ff < CNT_BITS'(3)) begin
               mul_a = head_op(mag_ff[cnt_ff[1:0]][HEAD_BITS-1:0]);
               mul_b = head_op(mag_ff[cnt_ff[1:0]][HEAD_BITS-1:0]);
            end
         end
         S_CROSS: begin
            case (cnt_ff)
               0: begin mul_a = MUL_BITS'(tu_ff[1]); mul_b = MUL_BITS'(bu_ff[2]); end
               1: begin mul_a = MUL_BITS'(tu_ff[2]); mul_b = MUL_BITS'(bu_ff[1]); end
               2: begin mul_a = MUL_BITS'(tu_ff[2]); mul_b = MUL_BITS'(bu_ff[0]); end
               3: begin mul_a = MUL_BITS'(tu_ff[0]); mul_b = MUL_BITS'(bu_ff[2]); end
               4: begin mul_a = MUL_BITS'(tu_ff[0]); mul_b = MUL_BITS'(bu_ff[1]); end
               5: begin mul_a = MUL_BITS'(tu_ff[1]); mul_b = MUL_BITS'(bu_ff[0]); end
               default: ;
            endcase
         end
         S_DOT: begin
            if (cnt_ff < CNT_BITS'(3)) begin
               mul_a = head_op(mag_ff[cnt_ff[1:0]][HEAD_BITS-1:0]);
               mul_b = head_op(nm_ff[cnt_ff[1:0]]);
            end
         end
         default: ;
      endcase
   end

   // State register and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers, no reset
   always_ff @(posedge clock) begin
      vsel_ff <= vsel_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      tri_ff  <= tri_in;
      nrm_ff  <= nrm_in;
      tg_ff   <= tg_in;
      bn_ff   <= bn_in;
      cr_ff   <= cr_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      nm_ff   <= nm_in;
      nn_ff   <= nn_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rx_ff   <= rx_in;
      r_ff    <= r_in;
      rbit_ff <= rbit_in;
      len_ff  <= len_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      tu_ff   <= tu_in;
      bu_ff   <= bu_in;
      deg_ff  <= deg_in;
      rsp_ff  <= rsp_in;
   end

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      vsel_in      = vsel_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      tri_in       = tri_ff;
      nrm_in       = nrm_ff;
      tg_in        = tg_ff;
      bn_in        = bn_ff;
      cr_in        = cr_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      nm_in        = nm_ff;
      nn_in        = nn_ff;
      acc_in       = acc_ff;
      rx_in        = rx_ff;
      r_in         = r_ff;
      rbit_in      = rbit_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      q_in         = q_ff;
      tu_in        = tu_ff;
      bu_in        = bu_ff;
      deg_in       = deg_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      pop_ready    = 1'b0;
      src          = nrm_ff;
      absv         = '0;
      orv          = mag_ff[0] | mag_ff[1] | mag_ff[2];
      prev         = cnt_ff - 1'b1;
      pair         = VEC_BITS'(acc_ff - prod_ff);
      term         = (neg_ff[prev[1:0]] != nn_ff[prev[1:0]]) ? -prod_ff : prod_ff;
      dotv         = acc_ff + term;
      root_t       = r_ff + rbit_ff;
      root_r       = r_ff >> 1;
      ge           = (rem_ff >= dsh_ff);
      qn           = {q_ff[QUO_BITS-2:0], ge};
      uval         = neg_ff[idx_ff] ? $signed(-qn) : $signed(qn);

      // Drop the result once transferred
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               tri_in   = pop_data;
               cnt_in   = '0;
               deg_in   = 1'b0;
               state_in = S_PROD;
            end
         end

         // Eighteen products, paired into normal, tangent and binormal components
         S_PROD: begin
            if (cnt_ff != '0) begin
               if (!prev[0]) begin
                  acc_in = prod_ff;
               end else begin
                  case (prev[CNT_BITS-1:1])
                     0: nrm_in[0] = pair;
                     1: nrm_in[1] = pair;
                     2: nrm_in[2] = pair;
                     3: tg_in[0]  = pair;
                     4: tg_in[1]  = pair;
                     5: tg_in[2]  = pair;
                     6: bn_in[0]  = pair;
                     7: bn_in[1]  = pair;
                     8: bn_in[2]  = pair;
                     default: ;
                  endcase
               end
            end
            if (cnt_ff == CNT_BITS'(PROD_COUNT)) begin
               vsel_in  = VS_NRM;
               state_in = S_LOAD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // Split the selected vector into sign and magnitude
         S_LOAD: begin
            case (vsel_ff)
               VS_NRM:  src = nrm_ff;
               VS_TAN:  src = tg_ff;
               VS_BIN:  src = bn_ff;
               default: src = cr_ff;
            endcase
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = src[i][VEC_BITS-1];
               absv      = src[i][VEC_BITS-1] ? $unsigned(-src[i]) : $unsigned(src[i]);
               mag_in[i] = MAG_BITS'(absv);
            end
            state_in = S_FIT;
         end

         // Shift one bit a cycle until the largest magnitude has a full head
         S_FIT: begin
            if (orv == '0) begin
               if (vsel_ff != VS_CRS) begin
                  deg_in = 1'b1;
               end
               state_in = S_OUT;
            end else if ((orv >> HEAD_BITS) != '0) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] >> 1;
               end
            end else if (!orv[HEAD_BITS-1]) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] << 1;
               end
            end else begin
               cnt_in = '0;
               case (vsel_ff)
                  VS_NRM: begin
                     for (int i = 0; i < 3; i++) begin
                        nm_in[i] = mag_ff[i][HEAD_BITS-1:0];
                     end
                     nn_in    = neg_ff;
                     vsel_in  = VS_TAN;
                     state_in = S_LOAD;
                  end
                  VS_CRS:  state_in = S_DOT;
                  default: state_in = S_SQ;
               endcase
            end
         end

         // Sum of squares
         S_SQ: begin
            if (cnt_ff != '0) begin
               acc_in = (prev == '0) ? prod_ff : acc_ff + prod_ff;
            end
            if (cnt_ff == CNT_BITS'(3)) begin
               rx_in    = SUM_BITS'(acc_ff + prod_ff);
               r_in     = '0;
               rbit_in  = SUM_BITS'(1) << (2 * HEAD_BITS);
               state_in = S_ROOT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // Digit-by-digit integer square root, one result bit a cycle
         S_ROOT: begin
            if (rx_ff >= root_t) begin
               rx_in  = rx_ff - root_t;
               root_r = (r_ff >> 1) + rbit_ff;
            end
            r_in    = root_r;
            rbit_in = rbit_ff >> 2;
            if (rbit_ff == SUM_BITS'(1)) begin
               len_in   = LEN_BITS'(root_r);
               idx_in   = '0;
               state_in = S_DINIT;
            end
         end

         // Load dividend with rounding half and the aligned divisor
         S_DINIT: begin
            rem_in = (DIV_BITS'(mag_ff[idx_ff][HEAD_BITS-1:0]) << UNIT_FRAC_BITS)
                     + DIV_BITS'(len_ff >> 1);
            dsh_in   = DIV_BITS'(len_ff) << (QUO_BITS - 1);
            q_in     = '0;
            cnt_in   = CNT_BITS'(QUO_BITS - 1);
            state_in = S_DIV;
         end

         // Restoring division, one quotient bit a cycle
         S_DIV: begin
            if (ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            q_in   = qn;
            dsh_in = dsh_ff >> 1;
            if (cnt_ff == '0) begin
               if (vsel_ff == VS_TAN) begin
                  tu_in[idx_ff] = uval;
               end else begin
                  bu_in[idx_ff] = uval;
               end
               if (idx_ff == 2'd2) begin
                  cnt_in = '0;
                  if (vsel_ff == VS_TAN) begin
                     vsel_in  = VS_BIN;
                     state_in = S_LOAD;
                  end else begin
                     state_in = S_CROSS;
                  end
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = S_DINIT;
               end
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end

         // Cross product of the unit tangent and binormal
         S_CROSS: begin
            if (cnt_ff != '0) begin
               if (!prev[0]) begin
                  acc_in = prod_ff;
               end else begin
                  cr_in[prev[2:1]] = pair;
               end
            end
            if (cnt_ff == CNT_BITS'(CROSS_COUNT)) begin
               vsel_in  = VS_CRS;
               state_in = S_LOAD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // Signed dot product against the normal; flip the tangent if negative
         S_DOT: begin
            if (cnt_ff != '0) begin
               acc_in = (prev == '0) ? term : dotv;
            end
            if (cnt_ff == CNT_BITS'(3)) begin
               if (dotv < 0) begin
                  for (int i = 0; i < 3; i++) begin
                     tu_in[i] = -tu_ff[i];
                  end
               end
               state_in = S_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // Hand the result to the output register
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.tangent_x  = deg_ff ? '0 : tu_ff[0];
               rsp_in.tangent_y  = deg_ff ? '0 : tu_ff[1];
               rsp_in.tangent_z  = deg_ff ? '0 : tu_ff[2];
               rsp_in.binormal_x = deg_ff ? '0 : bu_ff[0];
               rsp_in.binormal_y = deg_ff ? '0 : bu_ff[1];
               rsp_in.binormal_z = deg_ff ? '0 : bu_ff[2];
               rsp_in.degenerate = deg_ff;
               state_in          = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/triangle_tangent_binormal.sv =====
// Triangle tangent/binormal unit: front end, triangle queue and back-end sequencer.
// Vertices are taken one per cycle; the third vertex of a triangle only while the two-entry triangle queue has room.
// The back end works on one triangle at a time, popping the next only from idle. It
// shifts one bit a step to normalize each of four vectors and runs a 31-step square
// root and 16-step divisions on one shared multiplier. Degenerate triangles finish early.
// Synchronous reset clears the vertex phase, queue, sequencer and result valid.
`default_nettype none

module triangle_tangent_binormal (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ttb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ttb_pkg::rsp_type rsp_data
);
   import ttb_pkg::*;

   logic    push_valid, push_ready;
   tri_type push_data;
   logic    pop_valid, pop_ready;
   tri_type pop_data;

   ttb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ttb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ttb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/core/ttb_checker.sv =====
// Port-level checks of the triangle tangent/binormal unit, bound to the top level.
// Depends on ttb_pkg and triangle_tangent_binormal.
`default_nettype none

module ttb_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ttb_pkg::rsp_type rsp_data
);
   import ttb_pkg::*;

   function automatic logic in_unit(input logic signed [OUT_BITS-1:0] c);
      in_unit = (c <= UNIT_ONE) && (c >= -UNIT_ONE);
   endfunction

   // Hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // No result right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Degenerate results carry zero vectors
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         (rsp_data.tangent_x == '0) && (rsp_data.tangent_y == '0) &&
         (rsp_data.tangent_z == '0) && (rsp_data.binormal_x == '0) &&
         (rsp_data.binormal_y == '0) && (rsp_data.binormal_z == '0))
      else $error("degenerate result with nonzero vector");

   // Unit components never exceed one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         in_unit(rsp_data.tangent_x) && in_unit(rsp_data.tangent_y) &&
         in_unit(rsp_data.tangent_z) && in_unit(rsp_data.binormal_x) &&
         in_unit(rsp_data.binormal_y) && in_unit(rsp_data.binormal_z))
      else $error("unit component out of range");

endmodule

bind triangle_tangent_binormal ttb_checker u_checker (.*);

`default_nettype wire
